[src/gaussian_rejection_sampler_defines.svh]
// Assertion macros for the Gaussian rejection sampler checker.
// Depends on signals named clk and rst in the scope of each use.
`ifndef GAUSSIAN_REJECTION_SAMPLER_DEFINES_SVH
`define GAUSSIAN_REJECTION_SAMPLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GRS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GRS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/grs_pkg.sv]
// Shared types, widths, register codes and the 2^(-k/16) table for the
// Gaussian rejection sampler. No dependencies.
package grs_pkg;

  localparam int UNIFORM_BITS       = 16;
  localparam int VELOCITY_FRAC_BITS = 20;

  localparam int HR_W   = 21;
  localparam int CFG_W  = 16;
  localparam int VEL_W  = 22;
  localparam int MAG_W  = HR_W;
  localparam int SPAN_W = HR_W + 1;
  localparam int SPAN_PROD_W = SPAN_W + UNIFORM_BITS;
  localparam int HGT_PROD_W  = CFG_W + UNIFORM_BITS;

  localparam int SQ_W     = 2 * MAG_W;
  localparam int PART_W   = SQ_W / 2;
  localparam int PP_W     = CFG_W + PART_W;
  localparam int PROD_W   = CFG_W + SQ_W;
  localparam int X_SHIFT  = 2 * VELOCITY_FRAC_BITS - 12;
  localparam int X_W      = PROD_W - X_SHIFT;
  localparam int XCUT_W   = 21;
  localparam int LOG2E_W  = 17;
  localparam int Y_FULL_W = XCUT_W + LOG2E_W;
  localparam int Y_W      = Y_FULL_W - 16;
  localparam int N_W      = Y_W - 16;
  localparam int TAB_W    = 17;
  localparam int DIFF_W   = 12;
  localparam int DR_W     = 2 * DIFF_W;
  localparam int DENS_PROD_W = CFG_W + TAB_W;

  localparam logic [LOG2E_W-1:0] LOG2E_Q16 = 17'd94548;

  localparam int REG_IDX_W = 2;
  localparam int CFG_DATA_W = HR_W;
  localparam logic [REG_IDX_W-1:0] REG_HALF_RANGE      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ENVELOPE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_EXP_COEFFICIENT = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DENSITY_PEAK    = 2'd3;

  localparam logic [HR_W-1:0]  RST_HALF_RANGE      = 21'd157286;
  localparam logic [CFG_W-1:0] RST_ENVELOPE_HEIGHT = 16'd26624;
  localparam logic [CFG_W-1:0] RST_EXP_COEFFICIENT = 16'd8368;
  localparam logic [CFG_W-1:0] RST_DENSITY_PEAK    = 16'd26419;

  localparam int FRONT_STAGES = 2;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int BACK_STAGES  = 8;
  localparam int CAPACITY     = FRONT_STAGES + QUEUE_DEPTH + BACK_STAGES;

  typedef struct packed {
    logic [HR_W-1:0]  half_range;
    logic [CFG_W-1:0] envelope_height;
    logic [CFG_W-1:0] exp_coefficient;
    logic [CFG_W-1:0] density_peak;
  } grs_cfg_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] velocity;
    logic [MAG_W-1:0]        mag;
    logic [CFG_W-1:0]        height;
  } grs_item_t;

  function automatic logic [TAB_W-1:0] pow2_neg(input logic [4:0] idx);
    logic [TAB_W-1:0] val;
    case (idx)
      5'd0:  val = 17'd65536;
      5'd1:  val = 17'd62757;
      5'd2:  val = 17'd60097;
      5'd3:  val = 17'd57549;
      5'd4:  val = 17'd55109;
      5'd5:  val = 17'd52773;
      5'd6:  val = 17'd50535;
      5'd7:  val = 17'd48393;
      5'd8:  val = 17'd46341;
      5'd9:  val = 17'd44376;
      5'd10: val = 17'd42495;
      5'd11: val = 17'd40693;
      5'd12: val = 17'd38968;
      5'd13: val = 17'd37316;
      5'd14: val = 17'd35734;
      5'd15: val = 17'd34219;
      default: val = 17'd32768;
    endcase
    return val;
  endfunction

endpackage

[src/grs_channels.sv]
// Valid/ready channel interfaces for the sampler's input words and results.
// Depends on grs_pkg for payload widths.
interface grs_in_if;
  logic                              valid;
  logic                              ready;
  logic [grs_pkg::UNIFORM_BITS-1:0]  uniform_a;
  logic [grs_pkg::UNIFORM_BITS-1:0]  uniform_b;
  modport source (output valid, uniform_a, uniform_b, input ready);
  modport sink (input valid, uniform_a, uniform_b, output ready);
endinterface

interface grs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [grs_pkg::VEL_W-1:0]  velocity;
  logic                              accepted;
  modport source (output valid, velocity, accepted, input ready);
  modport sink (input valid, velocity, accepted, output ready);
endinterface

[src/grs_front.sv]
// Front end: takes uniform words, forms the candidate velocity, its
// magnitude and the envelope height. Depends on grs_pkg and grs_in_if.
module grs_front (
  input  logic               clk,
  input  logic               rst,
  grs_in_if.sink             samples,
  input  grs_pkg::grs_cfg_t  cfg,
  input  logic               full,
  output logic               push,
  output grs_pkg::grs_item_t push_item
);
  import grs_pkg::*;

  logic                    valid1;
  logic                    valid2;
  logic                    en1;
  logic                    en2;
  logic [SPAN_PROD_W-1:0]  span_prod;
  logic [HGT_PROD_W-1:0]   hgt_prod;
  logic [SPAN_PROD_W-1:0]  span_prod_next;
  logic [HGT_PROD_W-1:0]   hgt_prod_next;
  logic [SPAN_W-1:0]       span;
  logic [SPAN_W-1:0]       scaled;
  logic signed [VEL_W:0]   vel_wide;
  logic signed [VEL_W:0]   mag_wide;
  grs_item_t               item;

  assign en2 = !valid2 || !full;
  assign en1 = !valid1 || en2;
  assign samples.ready = en1;
  assign push = valid2 && !full;

  assign span = {cfg.half_range, 1'b0};
  assign span_prod_next = span * samples.uniform_a;
  assign hgt_prod_next = cfg.envelope_height * samples.uniform_b;

  assign scaled = span_prod[SPAN_PROD_W-1:UNIFORM_BITS];
  assign vel_wide = $signed({1'b0, scaled}) - $signed({2'b00, cfg.half_range});
  assign mag_wide = vel_wide[VEL_W] ? -vel_wide : vel_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else begin
      if (en1) begin
        valid1 <= samples.valid;
      end
      if (en2) begin
        valid2 <= valid1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      span_prod <= span_prod_next;
      hgt_prod  <= hgt_prod_next;
    end
    if (en2) begin
      item.velocity <= vel_wide[VEL_W-1:0];
      item.mag      <= mag_wide[MAG_W-1:0];
      item.height   <= hgt_prod[HGT_PROD_W-1:UNIFORM_BITS];
    end
  end

  assign push_item = item;

endmodule

[src/grs_queue.sv]
// Short FIFO between the front and back ends of the sampler.
// Depends on grs_pkg for the entry type and depth.
module grs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  grs_pkg::grs_item_t push_item,
  input  logic               pop,
  output grs_pkg::grs_item_t head,
  output logic               full,
  output logic               empty
);
  import grs_pkg::*;

  grs_item_t           entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/grs_back.sv]
// Back end: squares the velocity, forms the exponent, evaluates the density
// through the exp table and compares it with the height. Depends on grs_pkg.
module grs_back (
  input  logic               clk,
  input  logic               rst,
  input  grs_pkg::grs_cfg_t  cfg,
  input  grs_pkg::grs_item_t head,
  input  logic               empty,
  output logic               pop,
  grs_out_if.source          trials
);
  import grs_pkg::*;

  logic [BACK_STAGES:1]    valid;
  logic [BACK_STAGES:1]    en;
  logic signed [VEL_W-1:0] vel_pipe [1:BACK_STAGES];
  logic [CFG_W-1:0]        hgt_pipe [1:BACK_STAGES-1];
  logic                    big_pipe [3:6];

  logic [SQ_W-1:0]         sq;
  logic [SQ_W-1:0]         sq_next;
  logic [PP_W-1:0]         pp_lo;
  logic [PP_W-1:0]         pp_hi;
  logic [PP_W-1:0]         pp_lo_next;
  logic [PP_W-1:0]         pp_hi_next;
  logic [PROD_W-1:0]       prod_sum;
  logic [X_W-1:0]          x_full;
  logic [XCUT_W-1:0]       x_low;
  logic [Y_FULL_W-1:0]     y_full;
  logic [Y_W-1:0]          y;
  logic [N_W-1:0]          n_next;
  logic [3:0]              tab_idx;
  logic [DIFF_W-1:0]       tab_frac;
  logic [TAB_W-1:0]        tab_hi;
  logic [TAB_W-1:0]        tab_lo;
  logic [TAB_W-1:0]        tab_diff;
  logic [DR_W-1:0]         dr_next;
  logic [TAB_W-1:0]        hi5;
  logic [DR_W-1:0]         dr5;
  logic [N_W-1:0]          n5;
  logic [TAB_W-1:0]        interp;
  logic [TAB_W-1:0]        shifted;
  logic [TAB_W-1:0]        e6;
  logic [DENS_PROD_W-1:0]  dens_next;
  logic [DENS_PROD_W-1:0]  dens7;
  logic                    accepted8;

  always_comb begin
    en[BACK_STAGES] = !valid[BACK_STAGES] || trials.ready;
    for (int k = BACK_STAGES - 1; k >= 1; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign pop = en[1] && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[1]) begin
        valid[1] <= !empty;
      end
      for (int k = 2; k <= BACK_STAGES; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign sq_next    = head.mag * head.mag;
  assign pp_lo_next = cfg.exp_coefficient * sq[PART_W-1:0];
  assign pp_hi_next = cfg.exp_coefficient * sq[SQ_W-1:PART_W];
  assign prod_sum   = {pp_hi, {PART_W{1'b0}}} + {{PART_W{1'b0}}, pp_lo};
  assign x_full     = prod_sum[PROD_W-1:X_SHIFT];
  assign y_full     = x_low * LOG2E_Q16;
  assign n_next     = y[Y_W-1:16];
  assign tab_idx    = y[15:12];
  assign tab_frac   = y[11:0];
  assign tab_hi     = pow2_neg({1'b0, tab_idx});
  assign tab_lo     = pow2_neg({1'b0, tab_idx} + 5'd1);
  assign tab_diff   = tab_hi - tab_lo;
  assign dr_next    = tab_diff[DIFF_W-1:0] * tab_frac;
  assign interp     = hi5 - {{(TAB_W-DIFF_W){1'b0}}, dr5[DR_W-1:DIFF_W]};
  assign shifted    = interp >> n5;
  assign dens_next  = cfg.density_peak * e6;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sq          <= sq_next;
      vel_pipe[1] <= head.velocity;
      hgt_pipe[1] <= head.height;
    end
    if (en[2]) begin
      pp_lo <= pp_lo_next;
      pp_hi <= pp_hi_next;
    end
    if (en[3]) begin
      x_low       <= x_full[XCUT_W-1:0];
      big_pipe[3] <= |x_full[X_W-1:XCUT_W];
    end
    if (en[4]) begin
      y           <= y_full[Y_FULL_W-1:16];
      big_pipe[4] <= big_pipe[3];
    end
    if (en[5]) begin
      hi5         <= tab_hi;
      dr5         <= dr_next;
      n5          <= n_next;
      big_pipe[5] <= big_pipe[4];
    end
    if (en[6]) begin
      e6          <= big_pipe[5] ? '0 : shifted;
      big_pipe[6] <= big_pipe[5];
    end
    if (en[7]) begin
      dens7 <= big_pipe[6] ? '0 : dens_next;
    end
    if (en[8]) begin
      accepted8 <= dens7[DENS_PROD_W-1:16] >= {1'b0, hgt_pipe[7]};
    end
    for (int k = 2; k <= BACK_STAGES; k++) begin
      if (en[k]) begin
        vel_pipe[k] <= vel_pipe[k-1];
      end
    end
    for (int k = 2; k <= BACK_STAGES - 1; k++) begin
      if (en[k]) begin
        hgt_pipe[k] <= hgt_pipe[k-1];
      end
    end
  end

  assign trials.valid    = valid[BACK_STAGES];
  assign trials.velocity = vel_pipe[BACK_STAGES];
  assign trials.accepted = accepted8;

endmodule

[src/gaussian_rejection_sampler.sv]
// Gaussian rejection sampler, top level: configuration registers, front end,
// queue and back end. Depends on grs_pkg, grs_channels, grs_front, grs_queue,
// grs_back.
//
// Each transfer on the samples channel carries two uniform words and is one
// rejection-sampling trial; each produces exactly one transfer on the trials
// channel with the candidate velocity and an accepted flag. Results leave in
// the order their words arrived; the consumer drops rejected trials.
// A new item can be taken every cycle while the receiver takes every result.
// With no stall, an input transfer loads the first of two front stages,
// then passes through the queue and the eight back stages, the longest
// path being the chain of multipliers in the back end.
// When the receiver stalls, the back end holds; the four-entry queue and the
// front stages keep absorbing input until up to 14 items are in flight, and
// only then does samples.ready drop. Reset is synchronous and active high;
// it empties every stage and the queue and loads the default register values.
// Registers are written through cfg_we, cfg_index and cfg_data. The user must
// write them only while no trial is in flight; the block does not enforce it.
module gaussian_rejection_sampler (
  input  logic                            clk,
  input  logic                            rst,
  grs_in_if.sink                          samples,
  grs_out_if.source                       trials,
  input  logic                            cfg_we,
  input  logic [grs_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [grs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import grs_pkg::*;

  grs_cfg_t  cfg;
  grs_item_t push_item;
  grs_item_t head;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_range      <= RST_HALF_RANGE;
      cfg.envelope_height <= RST_ENVELOPE_HEIGHT;
      cfg.exp_coefficient <= RST_EXP_COEFFICIENT;
      cfg.density_peak    <= RST_DENSITY_PEAK;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_RANGE:      cfg.half_range      <= cfg_data;
        REG_ENVELOPE_HEIGHT: cfg.envelope_height <= cfg_data[CFG_W-1:0];
        REG_EXP_COEFFICIENT: cfg.exp_coefficient <= cfg_data[CFG_W-1:0];
        REG_DENSITY_PEAK:    cfg.density_peak    <= cfg_data[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  grs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .cfg       (cfg),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  grs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  grs_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .trials (trials)
  );

endmodule

[src/grs_checker.sv]
// Port-level checker for the Gaussian rejection sampler and its bind.
// Depends on grs_pkg and gaussian_rejection_sampler_defines.svh.
`include "gaussian_rejection_sampler_defines.svh"

module grs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            samples_valid,
  input logic                            samples_ready,
  input logic                            trials_valid,
  input logic                            trials_ready,
  input logic signed [grs_pkg::VEL_W-1:0] trials_velocity,
  input logic                            trials_accepted,
  input logic                            cfg_we,
  input logic [grs_pkg::REG_IDX_W-1:0]   cfg_index,
  input logic [grs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import grs_pkg::*;

  localparam int OUT_W = $clog2(CAPACITY + 1) + 1;

  logic [OUT_W-1:0] outstanding;
  logic             hr_zero;
  logic             in_xfer;
  logic             out_xfer;

  assign in_xfer  = samples_valid && samples_ready;
  assign out_xfer = trials_valid && trials_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      hr_zero     <= 1'b0;
    end else begin
      if (in_xfer && !out_xfer) begin
        outstanding <= outstanding + 1'b1;
      end else if (out_xfer && !in_xfer) begin
        outstanding <= outstanding - 1'b1;
      end
      if (cfg_we && cfg_index == REG_HALF_RANGE) begin
        hr_zero <= (cfg_data == '0);
      end
    end
  end

  `GRS_ASSERT_NXT(a_stall_hold, trials_valid && !trials_ready, trials_valid && $stable(trials_velocity) && $stable(trials_accepted), "Result changed while stalled")

  `GRS_ASSERT_IMP(a_no_invented, trials_valid, outstanding != '0, "Result shown with no trial in flight")

  `GRS_ASSERT_IMP(a_capacity, 1'b1, outstanding <= OUT_W'(CAPACITY), "More trials in flight than the pipeline holds")

  `GRS_ASSERT_IMP(a_zero_range, trials_valid && hr_zero, trials_velocity == '0, "Nonzero velocity with zero half range")

endmodule

bind gaussian_rejection_sampler grs_checker u_grs_checker (
  .clk             (clk),
  .rst             (rst),
  .samples_valid   (samples.valid),
  .samples_ready   (samples.ready),
  .trials_valid    (trials.valid),
  .trials_ready    (trials.ready),
  .trials_velocity (trials.velocity),
  .trials_accepted (trials.accepted),
  .cfg_we          (cfg_we),
  .cfg_index       (cfg_index),
  .cfg_data        (cfg_data)
);
